[hdl/assert_macros.svh]
// Assertion macros used by the RTL file of the step pulse generator.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mspg_pkg.sv]
// Shared constants and types for the multi-axis step pulse generator.
// No dependencies.
package mspg_pkg;

  localparam int NUM_AXES   = 3;
  localparam int POS_WIDTH  = 32;
  localparam int CNT_WIDTH  = 32;
  localparam int REP_AXES   = 3;   // axes reported on the result stream
  localparam int REP_WIDTH  = 32;  // width of a reported position

  localparam int CMD_WIDTH  = 2;
  localparam int AXIS_WIDTH = 2;

  localparam logic [CMD_WIDTH-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_STOP = 2'd2;

  localparam int IN_USER_WIDTH = CMD_WIDTH + AXIS_WIDTH;
  localparam int IN_DATA_WIDTH = 64;

  localparam int RES_BITS       = 3 * REP_AXES + REP_AXES * REP_WIDTH;
  localparam int OUT_DATA_WIDTH = ((RES_BITS + 7) / 8) * 8;

  typedef logic [NUM_AXES-1:0][POS_WIDTH-1:0] pos_vec_t;
  typedef logic [NUM_AXES-1:0][CNT_WIDTH-1:0] cnt_vec_t;
  typedef logic [OUT_DATA_WIDTH-1:0]          out_data_t;

endpackage

[hdl/multi_axis_step_pulse_generator.sv]
// Multi-axis step/direction pulse generator: command decode, per-axis
// motion state and a two-entry result buffer. Depends on mspg_pkg and
// assert_macros.svh.
//
// The block takes one command per clock (tick, set target, stop all) and
// returns exactly one result per command: the step, direction and moving
// bits of each axis and the positions after the command. All axes update in
// parallel within the accepting cycle, so a command may be accepted on every
// clock; its result is registered in the output or skid entry. A two-entry
// output buffer keeps input accepted while one result waits to be taken;
// s_axis_tready drops only when both entries are occupied.
`include "assert_macros.svh"

module multi_axis_step_pulse_generator
  import mspg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [31:0] target, [63:32] step_period
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,
  // [1:0] cmd, [3:2] axis
  input  logic [IN_USER_WIDTH-1:0]  s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [2:0] step_mask, [5:3] dir_mask, [8:6] moving_mask,
  // [40:9] pos_x, [72:41] pos_y, [104:73] pos_z, rest zero
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata
);

  logic [CMD_WIDTH-1:0]  cmd;
  logic [AXIS_WIDTH-1:0] axis;
  logic [31:0]           target;
  logic [CNT_WIDTH-1:0]  step_period;
  logic                  s_fire;
  logic                  m_fire;

  pos_vec_t              position, position_next;
  pos_vec_t              goal, goal_next;
  cnt_vec_t              period, period_next;
  cnt_vec_t              tick_count, tick_count_next;
  logic [NUM_AXES-1:0]   moving, moving_next;
  logic [NUM_AXES-1:0]   direction, direction_next;
  logic [NUM_AXES-1:0]   step_vec;

  out_data_t             res_data;
  out_data_t             out_data;
  out_data_t             skid_data;
  logic                  out_valid;
  logic                  skid_valid;

  assign cmd         = s_axis_tuser[CMD_WIDTH-1:0];
  assign axis        = s_axis_tuser[CMD_WIDTH+AXIS_WIDTH-1:CMD_WIDTH];
  assign target      = s_axis_tdata[31:0];
  assign step_period = s_axis_tdata[63:32];

  assign s_axis_tready = !skid_valid;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Per-axis update for the command at the input.
  always_comb begin
    logic [CNT_WIDTH-1:0] cnt_inc;
    logic [POS_WIDTH-1:0] new_goal;
    logic                 go_up;
    logic                 arrive_up;
    logic                 arrive_dn;

    position_next   = position;
    goal_next       = goal;
    period_next     = period;
    tick_count_next = tick_count;
    moving_next     = moving;
    direction_next  = direction;
    step_vec        = '0;
    cnt_inc         = '0;
    go_up           = 1'b0;
    arrive_up       = 1'b0;
    arrive_dn       = 1'b0;
    new_goal        = POS_WIDTH'(signed'(target));

    unique case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          cnt_inc   = tick_count[i] + 1'b1;
          go_up     = $signed(goal[i]) > $signed(position[i]);
          arrive_up = goal[i] == position[i] + 1'b1;
          arrive_dn = goal[i] == position[i] - 1'b1;
          if (moving[i]) begin
            if (cnt_inc >= period[i]) begin
              tick_count_next[i] = '0;
              step_vec[i]        = 1'b1;
              if (go_up) begin
                position_next[i] = position[i] + 1'b1;
                if (arrive_up) moving_next[i] = 1'b0;
              end else begin
                position_next[i] = position[i] - 1'b1;
                if (arrive_dn) moving_next[i] = 1'b0;
              end
            end else begin
              tick_count_next[i] = cnt_inc;
            end
          end
        end
      end
      CMD_SET: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (32'(axis) == i) begin
            goal_next[i]       = new_goal;
            period_next[i]     = step_period;
            tick_count_next[i] = '0;
            direction_next[i]  = $signed(new_goal) >= $signed(position[i]);
            moving_next[i]     = new_goal != position[i];
          end
        end
      end
      CMD_STOP: begin
        moving_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Pack the result from the updated state.
  always_comb begin
    res_data = '0;
    for (int j = 0; j < REP_AXES; j++) begin
      if (j < NUM_AXES) begin
        res_data[j]              = step_vec[j];
        res_data[REP_AXES + j]   = direction_next[j];
        res_data[2*REP_AXES + j] = moving_next[j];
        res_data[3*REP_AXES + j*REP_WIDTH +: REP_WIDTH] =
          REP_WIDTH'(signed'(position_next[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      goal       <= '0;
      period     <= '0;
      tick_count <= '0;
      moving     <= '0;
      direction  <= '0;
    end else if (s_fire) begin
      position   <= position_next;
      goal       <= goal_next;
      period     <= period_next;
      tick_count <= tick_count_next;
      moving     <= moving_next;
      direction  <= direction_next;
    end
  end

  // Output register plus skid entry; the skid refills the output on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= s_fire || skid_valid || (out_valid && !m_fire);
      skid_valid <= skid_valid ? !m_fire : (s_fire && out_valid && !m_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (m_fire && skid_valid) begin
      out_data <= skid_data;
    end
    if (s_fire) begin
      if (!out_valid || (m_fire && !skid_valid)) begin
        out_data <= res_data;
      end else begin
        skid_data <= res_data;
      end
    end
  end

  `ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  `ASSERT_NEXT(a_stop_clears, s_fire && cmd == CMD_STOP, moving == '0, "moving after stop all")
  `ASSERT_NEXT(a_pos_on_tick, !(s_fire && cmd == CMD_TICK), $stable(position), "stray step")
  `ASSERT_NEXT(a_accept_shows, s_fire, m_axis_tvalid, "accepted command left no result")

endmodule

[test/tb_top.sv]
// Self-checking testbench for multi_axis_step_pulse_generator: directed and random tick,
// set-target, stop-all and unused commands are checked against a built-in motion predictor.
// Depends on mspg_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import mspg_pkg::*;

  localparam logic [CMD_WIDTH-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [AXIS_WIDTH-1:0] AXIS_X     = 2'd0;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Y     = 2'd1;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Z     = 2'd2;
  localparam logic [AXIS_WIDTH-1:0] AXIS_NONE  = 2'd3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 410;

  // Field order matches m_axis_tdata from the top bit of the result down.
  typedef struct packed {
    logic [REP_WIDTH-1:0] pos_z;
    logic [REP_WIDTH-1:0] pos_y;
    logic [REP_WIDTH-1:0] pos_x;
    logic [2:0]           moving_mask;
    logic [2:0]           dir_mask;
    logic [2:0]           step_mask;
  } axis_report_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata = '0;
  logic [IN_USER_WIDTH-1:0]  s_axis_tuser = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

  // Predicted motion state, one entry per axis.
  logic signed [POS_WIDTH-1:0] cur_pos    [NUM_AXES];
  logic signed [POS_WIDTH-1:0] goal_pos   [NUM_AXES];
  logic [CNT_WIDTH-1:0]        step_ticks [NUM_AXES];
  logic [CNT_WIDTH-1:0]        tick_cnt   [NUM_AXES];
  bit                          moving     [NUM_AXES];
  bit                          dir_up     [NUM_AXES];

  axis_report_t expected_reports[$];
  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  multi_axis_step_pulse_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Advance the predicted axes by one command and queue the report it yields.
  function automatic void apply_command(input logic [CMD_WIDTH-1:0] cmd,
                                        input logic [AXIS_WIDTH-1:0] ax,
                                        input logic [31:0] tgt,
                                        input logic [31:0] per);
    axis_report_t rep;
    int i;
    rep = '0;
    case (cmd)
      CMD_SET: begin
        if (ax < NUM_AXES) begin
          goal_pos[ax]   = tgt;
          step_ticks[ax] = per;
          tick_cnt[ax]   = '0;
          dir_up[ax]     = (goal_pos[ax] >= cur_pos[ax]);
          moving[ax]     = (goal_pos[ax] != cur_pos[ax]);
        end
      end
      CMD_STOP: begin
        for (i = 0; i < NUM_AXES; i++) moving[i] = 1'b0;
      end
      CMD_TICK: begin
        for (i = 0; i < NUM_AXES; i++) begin
          if (moving[i]) begin
            tick_cnt[i] = tick_cnt[i] + 1'b1;
            if (tick_cnt[i] >= step_ticks[i]) begin
              tick_cnt[i] = '0;
              rep.step_mask[i] = 1'b1;
              if (goal_pos[i] > cur_pos[i]) cur_pos[i] = cur_pos[i] + 1;
              else cur_pos[i] = cur_pos[i] - 1;
              if (cur_pos[i] == goal_pos[i]) moving[i] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    for (i = 0; i < NUM_AXES; i++) begin
      rep.dir_mask[i]    = dir_up[i];
      rep.moving_mask[i] = moving[i];
    end
    rep.pos_x = cur_pos[0];
    rep.pos_y = cur_pos[1];
    rep.pos_z = cur_pos[2];
    expected_reports.push_back(rep);
  endfunction

  function automatic void compare_field(input string name, input logic [REP_WIDTH-1:0] want,
                                        input logic [REP_WIDTH-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_reports
    axis_report_t want;
    axis_report_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RES_BITS-1:0];
      if (expected_reports.size() == 0) begin
        $error("result transfer with no command pending: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("step_mask", REP_WIDTH'(want.step_mask), REP_WIDTH'(got.step_mask));
        compare_field("dir_mask", REP_WIDTH'(want.dir_mask), REP_WIDTH'(got.dir_mask));
        compare_field("moving_mask", REP_WIDTH'(want.moving_mask),
                      REP_WIDTH'(got.moving_mask));
        compare_field("pos_x", want.pos_x, got.pos_x);
        compare_field("pos_y", want.pos_y, got.pos_y);
        compare_field("pos_z", want.pos_z, got.pos_z);
        compare_field("pad", '0, REP_WIDTH'(m_axis_tdata[OUT_DATA_WIDTH-1:RES_BITS]));
      end
    end
  end

  // End the run when neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("multi_axis_step_pulse_generator verification failed");
        $finish;
      end
    end
  end

  task automatic send_command(input logic [CMD_WIDTH-1:0] cmd, input logic [AXIS_WIDTH-1:0] ax,
                              input logic [31:0] tgt, input logic [31:0] per);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {ax, cmd};
    s_axis_tdata  <= {per, tgt};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_command(cmd, ax, tgt, per);
  endtask

  // Hold the sender off until every queued result has been taken.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic send_random_item();
    int pick;
    logic [AXIS_WIDTH-1:0] ax;
    logic [31:0] tgt;
    logic [31:0] per;
    pick = $urandom_range(99);
    ax   = AXIS_WIDTH'($urandom_range(2));
    tgt  = $urandom;
    per  = $urandom;
    if (pick < 55) begin
      send_command(CMD_TICK, AXIS_WIDTH'($urandom), tgt, per);
    end else if (pick < 87) begin
      // Mostly short moves at short periods so that axes step and arrive.
      case ($urandom_range(9))
        0: ;
        1: tgt = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        default: tgt = cur_pos[ax] + $urandom_range(12) - 6;
      endcase
      case ($urandom_range(9))
        0: ;
        1: per = $urandom_range(10, 4);
        default: per = $urandom_range(3);
      endcase
      if ($urandom_range(19) == 0) ax = AXIS_NONE;
      send_command(CMD_SET, ax, tgt, per);
    end else if (pick < 93) begin
      send_command(CMD_STOP, AXIS_WIDTH'($urandom), tgt, per);
    end else begin
      send_command(CMD_UNUSED, AXIS_WIDTH'($urandom), tgt, per);
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_command(CMD_TICK, AXIS_X, '0, '0);
    send_command(CMD_SET, AXIS_X, 32'd3, 32'd0);
    repeat (4) send_command(CMD_TICK, AXIS_X, '0, '0);
    send_command(CMD_SET, AXIS_Y, 32'hffff_fffe, 32'd2);
    repeat (4) send_command(CMD_TICK, AXIS_Y, '0, '0);
    // Goal equal to position: direction up, no motion.
    send_command(CMD_SET, AXIS_Z, 32'd0, 32'd1);
    send_command(CMD_SET, AXIS_X, 32'd3, 32'd0);
    send_command(CMD_SET, AXIS_X, 32'h7fff_ffff, 32'hffff_ffff);
    send_command(CMD_SET, AXIS_Y, 32'h8000_0000, 32'd1);
    send_command(CMD_SET, AXIS_Z, 32'd5, 32'd1);
    send_command(CMD_TICK, AXIS_NONE, 32'hffff_ffff, 32'hffff_ffff);
    send_command(CMD_UNUSED, AXIS_NONE, 32'hffff_ffff, 32'hffff_ffff);
    send_command(CMD_SET, AXIS_NONE, 32'd100, 32'd0);
    send_command(CMD_SET, AXIS_X, 32'd3, 32'd0);
    send_command(CMD_STOP, AXIS_X, '0, '0);
    send_command(CMD_TICK, AXIS_X, '0, '0);
    send_command(CMD_SET, AXIS_Z, 32'hffff_ffff, 32'd0);
    repeat (2) send_command(CMD_TICK, AXIS_Z, '0, '0);
    wait_for_results();
  endtask

  task automatic test_random_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (PHASE_ITEMS) send_random_item();
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct  = 87;
    recv_stall_pct = 0;
    repeat (PHASE_ITEMS) send_random_item();
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 87;
    repeat (PHASE_ITEMS) send_random_item();
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    repeat (PHASE_ITEMS / 2) send_random_item();
    wait_for_results();
    repeat (PHASE_ITEMS / 2) send_random_item();
  endtask

  initial begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cur_pos[i]    = '0;
      goal_pos[i]   = '0;
      step_ticks[i] = '0;
      tick_cnt[i]   = '0;
      moving[i]     = 1'b0;
      dir_up[i]     = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("multi_axis_step_pulse_generator verification clean");
    end else begin
      $display("multi_axis_step_pulse_generator verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/mspg_pkg.sv
hdl/multi_axis_step_pulse_generator.sv
test/tb_top.sv
